@@ rtl/cqdn_pkg.sv @@
// Shared types and constants for the quaternion decode and normalise block.
package cqdn_pkg;

    localparam int unsigned LANES     = 4;
    localparam int unsigned NBITS     = 16;
    localparam int unsigned CELLS     = NBITS;
    localparam int unsigned REM_W     = 63;
    localparam int unsigned ACC_W     = 66;
    localparam logic [29:0] QSCALE_SQ = 30'd1073676289;
    localparam logic [31:0] MIN_SUMSQ = 32'd1074;
    localparam logic signed [15:0] QSCALE = 16'sd32767;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
        logic signed [15:0] raw_w;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] norm_w;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               degenerate;
    } t_out_word;

    // Word passed along the root chain; lane 0..3 = x, y, z, w.
    typedef struct packed {
        logic [LANES-1:0]                neg;
        logic                            degen;
        logic [LANES-1:0][NBITS-1:0]     n;
        logic [LANES-1:0][REM_W-1:0]     rem;
        logic [LANES-1:0][ACC_W-1:0]     u;
        logic [ACC_W-1:0]                v;
    } t_cell_word;

endpackage

@@ rtl/cqdn_front.sv @@
// Front end: component decode, squares, sum of squares and chain seeding.
module cqdn_front import cqdn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_word   i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_word o_data
);

    logic                        r1_v, r2_v;
    logic [LANES-1:0]            r1_neg;
    logic [LANES-1:0][29:0]      r1_sq;
    t_cell_word                  r2_w;
    logic                        adv1, adv2;
    logic [LANES-1:0][15:0]      raw;
    logic [LANES-1:0][14:0]      mag;
    logic [LANES-1:0]            neg;
    logic [31:0]                 sum;

    assign adv2    = !r2_v || i_ready;
    assign adv1    = !r1_v || adv2;
    assign o_ready = adv1;
    assign o_valid = r2_v;
    assign o_data  = r2_w;

    assign raw[0] = i_data.raw_x;
    assign raw[1] = i_data.raw_y;
    assign raw[2] = i_data.raw_z;
    assign raw[3] = i_data.raw_w;

    // Negative code maps to its low bits; otherwise magnitude is 32767 - c.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            mag[i] = raw[i][15] ? raw[i][14:0] : ~raw[i][14:0];
            neg[i] = !raw[i][15] && (raw[i][14:0] != 15'h7fff);
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < LANES; i++) begin
            sum = sum + {2'b00, r1_sq[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (adv1) r1_v <= i_valid;
            if (adv2) r2_v <= r1_v;
        end
        if (adv1) begin
            r1_neg <= neg;
            for (int i = 0; i < LANES; i++) begin
                r1_sq[i] <= 30'(mag[i] * mag[i]);
            end
        end
        if (adv2) begin
            r2_w.neg   <= r1_neg;
            r2_w.degen <= sum < MIN_SUMSQ;
            r2_w.v     <= {4'b0, sum, 30'b0};
            for (int i = 0; i < LANES; i++) begin
                r2_w.n[i]   <= '0;
                r2_w.u[i]   <= '0;
                r2_w.rem[i] <= {1'b0, 60'(r1_sq[i] * QSCALE_SQ), 2'b00};
            end
        end
    end

endmodule

@@ rtl/cqdn_cell.sv @@
// One root cell: settles one bit of the scaled quotient in each lane.
module cqdn_cell import cqdn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cell_word i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cell_word o_data
);

    logic                   r_v;
    t_cell_word             r_w, n_w;
    logic                   adv;
    logic [ACC_W-1:0]       g, un;
    logic                   ok;

    assign adv     = !r_v || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v;
    assign o_data  = r_w;

    // Test (a + 2^k)^2 S <= R with u = aS<<(k+1), v = S<<2k held pre-shifted.
    always_comb begin
        n_w       = i_data;
        n_w.v     = i_data.v >> 2;
        g         = '0;
        un        = '0;
        ok        = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            g  = i_data.u[i] + i_data.v;
            ok = g <= {3'b000, i_data.rem[i]};
            un = ok ? i_data.u[i] + {i_data.v[ACC_W-2:0], 1'b0} : i_data.u[i];
            n_w.u[i]   = un >> 1;
            n_w.rem[i] = ok ? i_data.rem[i] - g[REM_W-1:0] : i_data.rem[i];
            n_w.n[i]   = {i_data.n[i][NBITS-2:0], ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= i_valid;
        end
        if (adv) r_w <= n_w;
    end

endmodule

@@ rtl/compressed_quaternion_decode_normalize.sv @@
// Top level: decode, normalise and identity substitution for packed quaternions.
// Accepts one compressed quaternion word per cycle while o_ready is high and
// returns one normalised word per input. The result sits behind 19 register
// stages: two front-end stages (decode and squares, then sum of squares and
// the 4*m^2*32767^2 product), a chain of 16 root cells that each settle one
// bit of floor(2*m*32767/sqrt(S)) for all four lanes, and a registered output
// stage that halves that with rounding and applies signs. Every stage has its
// own valid bit and a ready chain, so bubbles collapse and the block keeps
// taking words while a finished result waits, until every stage holds a word.
// Words whose sum of squares is below 1074 come out as the identity with
// degenerate set.
module compressed_quaternion_decode_normalize import cqdn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    t_cell_word          w   [CELLS+1];
    logic [CELLS:0]      v;
    logic [CELLS:0]      rdy;
    logic                r_v;
    t_out_word           r_out, n_out;
    logic                adv;
    logic [LANES-1:0][15:0] res;

    cqdn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (v[0]),
        .i_ready (rdy[0]),
        .o_data  (w[0])
    );

    // Root chain, most significant bit first.
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        cqdn_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[k]),
            .o_ready (rdy[k]),
            .i_data  (w[k]),
            .o_valid (v[k+1]),
            .i_ready (rdy[k+1]),
            .o_data  (w[k+1])
        );
    end

    assign adv        = !r_v || i_ready;
    assign rdy[CELLS] = adv;
    assign o_valid    = r_v;
    assign o_data     = r_out;

    // r = (n + 1) >> 1 gives round-half-away of m*32767/sqrt(S).
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [16:0] rr;
            rr     = ({1'b0, w[CELLS].n[i]} + 17'd1) >> 1;
            res[i] = w[CELLS].neg[i] ? 16'(-rr[15:0]) : rr[15:0];
        end
        if (w[CELLS].degen) begin
            n_out.norm_w = QSCALE;
            n_out.norm_x = '0;
            n_out.norm_y = '0;
            n_out.norm_z = '0;
        end else begin
            n_out.norm_w = res[3];
            n_out.norm_x = res[0];
            n_out.norm_y = res[1];
            n_out.norm_z = res[2];
        end
        n_out.degenerate = w[CELLS].degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (adv) begin
            r_v <= v[CELLS];
        end
        if (adv) r_out <= n_out;
    end

    // Identity word whenever the flag is up.
    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |->
            o_data.norm_w == QSCALE && o_data.norm_x == 16'sd0 &&
            o_data.norm_y == 16'sd0 && o_data.norm_z == 16'sd0)
        else $error("degenerate word is not identity");

    // Rounded results never reach the most negative code.
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.norm_w != 16'sh8000 && o_data.norm_x != 16'sh8000 &&
            o_data.norm_y != 16'sh8000 && o_data.norm_z != 16'sh8000)
        else $error("normalised component out of range");

    // A stalled result is not dropped by the output stage.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output word lost under stall");

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the compressed quaternion decode and normalise block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cqdn_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    t_out_word expected_norms[$];
    int        fail_count = 0;
    int        burst_left = 0;

    always #2 i_clk = ~i_clk;

    compressed_quaternion_decode_normalize DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Offset decode: negative codes shift up by 32768, the rest down by 32767.
    function automatic int decode_code(logic signed [15:0] c);
        int v;
        v = int'(c);
        return (v < 0) ? v + 32768 : v - 32767;
    endfunction

    // Largest r in [0,32767] with (2r-1)^2 * S <= 4 * m^2 * 32767^2:
    // round to nearest, ties away from zero, done exactly on magnitudes.
    function automatic logic signed [15:0] scale_comp(int d, longint unsigned s);
        longint unsigned m, rhs, t;
        logic [127:0]    lhs;
        int              lo, hi, mid;
        m   = (d < 0) ? -d : d;
        rhs = 4 * m * m * 32767 * 32767;
        lo  = 0;
        hi  = 32767;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 2 * mid - 1;
            lhs = 128'(t) * 128'(t) * 128'(s);
            if (lhs <= 128'(rhs)) lo = mid;
            else hi = mid - 1;
        end
        return (d < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic t_out_word normalise_quat(t_in_word w);
        int              dx, dy, dz, dw;
        longint unsigned s;
        t_out_word       r;
        dx = decode_code(w.raw_x);
        dy = decode_code(w.raw_y);
        dz = decode_code(w.raw_z);
        dw = decode_code(w.raw_w);
        s  = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz + longint'(dw) * dw;
        if (s < MIN_SUMSQ) begin
            // too short: identity with the flag raised
            r = '0;
            r.norm_w     = QSCALE;
            r.degenerate = 1'b1;
        end else begin
            r.norm_w     = scale_comp(dw, s);
            r.norm_x     = scale_comp(dx, s);
            r.norm_y     = scale_comp(dy, s);
            r.norm_z     = scale_comp(dz, s);
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    // Send one word; bursts of random length separated by random gaps.
    // Valid stays up between words of a burst and drops only for a gap.
    task automatic send_word(t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= w;
        expected_norms = {expected_norms, normalise_quat(w)};
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid after the last accepted word and wait for the pipe to empty.
    task automatic drain_all();
        i_valid <= 1'b0;
        while (expected_norms.size() != 0) @(posedge i_clk);
    endtask

    // Builds a word from decoded values (each in [-32767,32767]).
    function automatic t_in_word encode_quat(int x, int y, int z, int w);
        t_in_word r;
        r.raw_x = 16'((x > 0) ? x - 32768 : (x < 0 ? x + 32767 : 32767));
        r.raw_y = 16'((y > 0) ? y - 32768 : (y < 0 ? y + 32767 : 32767));
        r.raw_z = 16'((z > 0) ? z - 32768 : (z < 0 ? z + 32767 : 32767));
        r.raw_w = 16'((w > 0) ? w - 32768 : (w < 0 ? w + 32767 : 32767));
        return r;
    endfunction

    task automatic test_directed();
        send_word('{16'h8000, 16'h8000, 16'h8000, 16'h8000}); // all codes decode to zero
        send_word('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}); // the other zero code
        send_word('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}); // all +32767
        send_word('{16'h0000, 16'h0000, 16'h0000, 16'h0000}); // all -32767
        send_word('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        send_word(encode_quat(0, 0, 0, 32767));
        send_word(encode_quat(-32767, 0, 0, 0));
        send_word(encode_quat(32, 5, 0, 0));    // S = 1049, just short
        send_word(encode_quat(32, 7, 0, 0));    // S = 1073, one below threshold
        send_word(encode_quat(0, 0, 0, 33));    // S = 1089, just above
        send_word(encode_quat(30, 9, 3, 1));    // S = 991, below threshold
        send_word(encode_quat(25, 15, 10, 6));  // S = 986
        send_word(encode_quat(25, 17, 10, 6));  // S = 1050
        send_word(encode_quat(-1, 1, -1, 1));
        send_word(encode_quat(1, 1, 1, 1));
        send_word(encode_quat(-32767, 32767, -32767, 32767));
        send_word(encode_quat(3, 4, 0, 0));
        send_word(encode_quat(300, 400, 0, 0)); // exact 3-4-5 ratios
        send_word('{16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC});
    endtask

    task automatic test_random();
        t_in_word w;
        int       mag;
        for (int n = 0; n < 1330; n++) begin
            case ($urandom_range(0, 4))
                0: w = t_in_word'({$urandom, $urandom});
                1: begin
                    // small vectors around the short-quaternion threshold
                    mag = $urandom_range(1, 40);
                    w = encode_quat($urandom_range(0, 2 * mag) - mag,
                                    $urandom_range(0, 2 * mag) - mag,
                                    $urandom_range(0, 2 * mag) - mag,
                                    $urandom_range(0, 2 * mag) - mag);
                end
                2: begin
                    // one dominant lane, others tiny
                    w = encode_quat($urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                                    $urandom_range(0, 20) - 10, $urandom_range(0, 65534) - 32767);
                end
                3: begin
                    // codes mixing zero codes and extremes
                    w.raw_x = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
                    w.raw_y = ($urandom_range(0, 1)) ? 16'h0000 : 16'hFFFF;
                    w.raw_z = 16'($urandom);
                    w.raw_w = ($urandom_range(0, 1)) ? 16'h7FFF : 16'($urandom);
                end
                default: w = encode_quat($urandom_range(0, 65534) - 32767,
                                         $urandom_range(0, 65534) - 32767,
                                         $urandom_range(0, 65534) - 32767,
                                         $urandom_range(0, 65534) - 32767);
            endcase
            send_word(w);
            if (n == 600) begin
                // hold off until the pipe has drained completely
                drain_all();
                @(posedge i_clk);
            end
        end
    endtask

    // Receiver stall pattern: stretches of steady ready, then random stalls.
    initial begin
        int phase;
        @(posedge i_clk);
        forever begin
            phase = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60)) begin
                @(posedge i_clk);
                if (phase == 0) i_ready <= 1'b1;
                else if (phase == 1) i_ready <= ($urandom_range(0, 3) != 0);
                else i_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Result checker: compare every accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_norms.size() == 0) begin
                $error("unexpected output word %h", o_data);
                fail_count++;
            end else begin
                exp_w = expected_norms.pop_front();
                if (o_data.norm_w !== exp_w.norm_w) begin
                    $error("norm_w exp %0d got %0d", exp_w.norm_w, o_data.norm_w);
                    fail_count++;
                end
                if (o_data.norm_x !== exp_w.norm_x) begin
                    $error("norm_x exp %0d got %0d", exp_w.norm_x, o_data.norm_x);
                    fail_count++;
                end
                if (o_data.norm_y !== exp_w.norm_y) begin
                    $error("norm_y exp %0d got %0d", exp_w.norm_y, o_data.norm_y);
                    fail_count++;
                end
                if (o_data.norm_z !== exp_w.norm_z) begin
                    $error("norm_z exp %0d got %0d", exp_w.norm_z, o_data.norm_z);
                    fail_count++;
                end
                if (o_data.degenerate !== exp_w.degenerate) begin
                    $error("degenerate exp %0d got %0d", exp_w.degenerate, o_data.degenerate);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        drain_all();
        repeat (40) @(posedge i_clk); // catch any stray late words
        if (fail_count == 0 && expected_norms.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
